### rtl/core/z80_branch_predecoder_assert.svh
// Assertion macros for the Z80 branch predecoder.
// Expects clk_i and rst_ni in the scope of the module that includes it.
`ifndef Z80_BRANCH_PREDECODER_ASSERT_SVH
`define Z80_BRANCH_PREDECODER_ASSERT_SVH

// same-cycle implication
`define Z80BP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define Z80BP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/z80bp_pkg.sv
// Package for the Z80 branch predecoder: opcode codes, masks and the
// decoded word type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package z80bp_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 3;

  // opcodes
  localparam logic [7:0] OP_JP      = 8'hC3;
  localparam logic [7:0] OP_JR      = 8'h18;
  localparam logic [7:0] OP_RET     = 8'hC9;
  localparam logic [7:0] OP_JP_HL   = 8'hE9;
  localparam logic [7:0] OP_CALL    = 8'hCD;
  localparam logic [7:0] OP_DJNZ    = 8'h10;
  localparam logic [7:0] PFX_CB     = 8'hCB;
  localparam logic [7:0] PFX_ED     = 8'hED;
  localparam logic [7:0] PFX_DD     = 8'hDD;
  localparam logic [7:0] PFX_FD     = 8'hFD;
  localparam logic [7:0] ED_RETN    = 8'h45;
  localparam logic [7:0] ED_RETI    = 8'h4D;

  // second bytes after DD/FD that take a 16-bit or offset+immediate operand
  localparam logic [7:0] IX_LD_NN   = 8'h21;
  localparam logic [7:0] IX_ST_NN   = 8'h22;
  localparam logic [7:0] IX_LD_IND  = 8'h2A;
  localparam logic [7:0] IX_ST_N    = 8'h36;

  // match masks and values
  localparam logic [7:0] MSK_C7     = 8'hC7;
  localparam logic [7:0] MSK_E7     = 8'hE7;
  localparam logic [7:0] MSK_CF     = 8'hCF;
  localparam logic [7:0] MSK_C0     = 8'hC0;
  localparam logic [7:0] MSK_RST    = 8'h38;
  localparam logic [7:0] VAL_JP_CC  = 8'hC2;
  localparam logic [7:0] VAL_JR_CC  = 8'h20;
  localparam logic [7:0] VAL_CL_CC  = 8'hC4;
  localparam logic [7:0] VAL_RET_CC = 8'hC0;
  localparam logic [7:0] VAL_RST    = 8'hC7;
  localparam logic [7:0] VAL_ED_LD  = 8'h43;
  localparam logic [7:0] VAL_LD_N   = 8'h06;
  localparam logic [7:0] VAL_LD_NN  = 8'h01;
  localparam logic [7:0] VAL_ALU_N  = 8'hC6;
  localparam logic [7:0] VAL_IX_40  = 8'h40;
  localparam logic [7:0] VAL_IX_46  = 8'h46;

  localparam logic [LenW-1:0] LEN_1 = 3'd1;
  localparam logic [LenW-1:0] LEN_2 = 3'd2;
  localparam logic [LenW-1:0] LEN_3 = 3'd3;
  localparam logic [LenW-1:0] LEN_4 = 3'd4;

  typedef struct packed {
    logic [LenW-1:0]         length;
    logic                    uncond;
    logic                    cond;
    logic                    ret;
    logic                    call;
    logic                    tgt_ok;
    logic [AddrW-1:0]        target;
    logic signed [ByteW-1:0] rel;
  } decode_t;

endpackage

`default_nettype wire

### rtl/core/z80bp_decode.sv
// Combinational Z80 predecode: length, flow flags and static target.
// Depends on z80bp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module z80bp_decode (
  input  logic [z80bp_pkg::AddrW-1:0] addr_i,
  input  logic [z80bp_pkg::ByteW-1:0] op_i,
  input  logic [z80bp_pkg::ByteW-1:0] b1_i,
  input  logic [z80bp_pkg::ByteW-1:0] b2_i,
  output z80bp_pkg::decode_t          dec_o
);
  import z80bp_pkg::*;

  logic [AddrW-1:0] abs16;
  logic [AddrW-1:0] rel_tgt;

  assign abs16   = {b2_i, b1_i};
  assign rel_tgt = addr_i + AddrW'(2) + {{(AddrW-ByteW){b1_i[ByteW-1]}}, b1_i};

  always_comb begin
    dec_o = '0;
    dec_o.length = LEN_1;
    if (op_i == OP_JP) begin
      dec_o.length = LEN_3; dec_o.uncond = 1'b1; dec_o.tgt_ok = 1'b1;
      dec_o.target = abs16;
    end else if (op_i == OP_JR) begin
      dec_o.length = LEN_2; dec_o.uncond = 1'b1; dec_o.tgt_ok = 1'b1;
      dec_o.target = rel_tgt; dec_o.rel = b1_i;
    end else if (op_i == OP_RET) begin
      dec_o.uncond = 1'b1; dec_o.ret = 1'b1;
    end else if (op_i == OP_JP_HL) begin
      dec_o.uncond = 1'b1;
    end else if ((op_i & MSK_C7) == VAL_JP_CC) begin
      dec_o.length = LEN_3; dec_o.cond = 1'b1; dec_o.tgt_ok = 1'b1;
      dec_o.target = abs16;
    end else if ((op_i & MSK_E7) == VAL_JR_CC) begin
      dec_o.length = LEN_2; dec_o.cond = 1'b1; dec_o.tgt_ok = 1'b1;
      dec_o.target = rel_tgt; dec_o.rel = b1_i;
    end else if (op_i == OP_CALL) begin
      dec_o.length = LEN_3; dec_o.call = 1'b1; dec_o.tgt_ok = 1'b1;
      dec_o.target = abs16;
    end else if ((op_i & MSK_C7) == VAL_CL_CC) begin
      dec_o.length = LEN_3; dec_o.cond = 1'b1; dec_o.call = 1'b1;
      dec_o.tgt_ok = 1'b1; dec_o.target = abs16;
    end else if ((op_i & MSK_C7) == VAL_RET_CC) begin
      dec_o.cond = 1'b1; dec_o.ret = 1'b1;
    end else if ((op_i & MSK_C7) == VAL_RST) begin
      dec_o.call = 1'b1; dec_o.tgt_ok = 1'b1;
      dec_o.target = {{(AddrW-ByteW){1'b0}}, op_i & MSK_RST};
    end else if (op_i == OP_DJNZ) begin
      dec_o.length = LEN_2; dec_o.cond = 1'b1; dec_o.tgt_ok = 1'b1;
      dec_o.target = rel_tgt; dec_o.rel = b1_i;
    end else if (op_i == PFX_ED) begin
      if (b1_i inside {ED_RETN, ED_RETI}) begin
        dec_o.length = LEN_2; dec_o.uncond = 1'b1; dec_o.ret = 1'b1;
      end else begin
        dec_o.length = ((b1_i & MSK_C7) == VAL_ED_LD) ? LEN_4 : LEN_2;
      end
    end else if (op_i inside {PFX_DD, PFX_FD}) begin
      if (b1_i == OP_JP_HL) begin
        dec_o.length = LEN_2; dec_o.uncond = 1'b1;
      end else if (b1_i == PFX_CB) begin
        dec_o.length = LEN_4;
      end else if ((b1_i & MSK_C0) == VAL_IX_40 || (b1_i & MSK_C7) == VAL_IX_46) begin
        dec_o.length = LEN_3;
      end else if (b1_i inside {IX_LD_NN, IX_ST_NN, IX_LD_IND, IX_ST_N}) begin
        dec_o.length = LEN_4;
      end else begin
        dec_o.length = LEN_2;
      end
    end else if (op_i == PFX_CB) begin
      dec_o.length = LEN_2;
    end else if ((op_i & MSK_C7) == VAL_LD_N) begin
      dec_o.length = LEN_2;
    end else if ((op_i & MSK_CF) == VAL_LD_NN) begin
      dec_o.length = LEN_3;
    end else if ((op_i & MSK_C7) == VAL_ALU_N) begin
      dec_o.length = LEN_2;
    end
  end

endmodule

`default_nettype wire

### rtl/core/z80_branch_predecoder.sv
// Z80 branch predecoder top level: input register, decode, result register.
// Depends on z80bp_pkg, z80bp_decode and z80_branch_predecoder_assert.svh.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | instr_address, opcode/second/third byte
//   out     | output    | out_valid_o / out_stall_i | length, flow flags, target, offset
//
// One word per cycle sustained while out_stall_i is low.
// Decode sits between the input register and the result register.
// Reset clears only the two valid flags.
// A stall on the output holds the result; the input stalls only when
// both registers are full and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module z80_branch_predecoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [z80bp_pkg::AddrW-1:0]   instr_address_i,
  input  logic [z80bp_pkg::ByteW-1:0]   opcode_byte_i,
  input  logic [z80bp_pkg::ByteW-1:0]   second_byte_i,
  input  logic [z80bp_pkg::ByteW-1:0]   third_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [z80bp_pkg::LenW-1:0]    instr_length_o,
  output logic                          uncond_jump_o,
  output logic                          conditional_o,
  output logic                          is_return_o,
  output logic                          is_call_o,
  output logic                          has_target_o,
  output logic [z80bp_pkg::AddrW-1:0]   branch_target_o,
  output logic signed [z80bp_pkg::ByteW-1:0] rel_offset_o
);
  import z80bp_pkg::*;

`include "z80_branch_predecoder_assert.svh"

  logic             s1_valid_q, s1_valid_d;
  logic [AddrW-1:0] addr_q;
  logic [ByteW-1:0] op_q, b1_q, b2_q;
  logic             out_valid_q, out_valid_d;
  decode_t          dec, res_q;
  logic             s1_ready, s2_ready;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      addr_q <= instr_address_i;
      op_q   <= opcode_byte_i;
      b1_q   <= second_byte_i;
      b2_q   <= third_byte_i;
    end
  end

  z80bp_decode u_decode (
    .addr_i (addr_q),
    .op_i   (op_q),
    .b1_i   (b1_q),
    .b2_i   (b2_q),
    .dec_o  (dec)
  );

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      res_q <= dec;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign instr_length_o  = res_q.length;
  assign uncond_jump_o   = res_q.uncond;
  assign conditional_o   = res_q.cond;
  assign is_return_o     = res_q.ret;
  assign is_call_o       = res_q.call;
  assign has_target_o    = res_q.tgt_ok;
  assign branch_target_o = res_q.target;
  assign rel_offset_o    = res_q.rel;

  `Z80BP_ASSERT_NOW(a_tgt_zero, out_valid_o && !has_target_o, branch_target_o == '0, "target")
  `Z80BP_ASSERT_NOW(a_len, out_valid_o, instr_length_o >= LEN_1 && instr_length_o <= LEN_4, "len")
  `Z80BP_ASSERT_NOW(a_ret, out_valid_o && is_return_o, !has_target_o && !is_call_o, "ret flags")
  `Z80BP_ASSERT_NEXT(a_advance, s1_valid_q && s2_ready, out_valid_o, "decoded word lost")

endmodule

`default_nettype wire

### test/tb_z80_branch_predecoder.sv
// Self-checking testbench for z80_branch_predecoder: directed and random fetch
// windows, a decode predictor and a field-by-field result check.
// Depends on z80bp_pkg and the z80_branch_predecoder RTL.
`timescale 1ns / 1ps

module tb_z80_branch_predecoder;
  import z80bp_pkg::*;

  localparam int unsigned RandomWords = 1450;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned CalmFirst   = 500;
  localparam int unsigned CalmLast    = 700;

  localparam logic [7:0] OP_HALT   = 8'h76;
  localparam logic [7:0] OP_NOP    = 8'h00;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] op;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
  } fetch_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [AddrW-1:0]        instr_address_i = '0;
  logic [ByteW-1:0]        opcode_byte_i   = '0;
  logic [ByteW-1:0]        second_byte_i   = '0;
  logic [ByteW-1:0]        third_byte_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic [LenW-1:0]         instr_length_o;
  logic                    uncond_jump_o;
  logic                    conditional_o;
  logic                    is_return_o;
  logic                    is_call_o;
  logic                    has_target_o;
  logic [AddrW-1:0]        branch_target_o;
  logic signed [ByteW-1:0] rel_offset_o;

  fetch_t  fetch_q[$];
  decode_t decode_q[$];
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned targets_seen  = 0;
  int unsigned mismatches    = 0;

  z80_branch_predecoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .instr_address_i (instr_address_i),
    .opcode_byte_i   (opcode_byte_i),
    .second_byte_i   (second_byte_i),
    .third_byte_i    (third_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .instr_length_o  (instr_length_o),
    .uncond_jump_o   (uncond_jump_o),
    .conditional_o   (conditional_o),
    .is_return_o     (is_return_o),
    .is_call_o       (is_call_o),
    .has_target_o    (has_target_o),
    .branch_target_o (branch_target_o),
    .rel_offset_o    (rel_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic decode_t predict_decode(input fetch_t w);
    decode_t     d;
    logic [15:0] rel_dest;
    d        = '0;
    d.length = LEN_1;
    rel_dest = w.addr + 16'd2 + {{8{w.b1[7]}}, w.b1};
    if (w.op == OP_JP) begin
      d.length = LEN_3; d.uncond = 1'b1; d.tgt_ok = 1'b1; d.target = {w.b2, w.b1};
    end else if (w.op == OP_JR) begin
      d.length = LEN_2; d.uncond = 1'b1; d.tgt_ok = 1'b1; d.target = rel_dest; d.rel = w.b1;
    end else if (w.op == OP_RET) begin
      d.uncond = 1'b1; d.ret = 1'b1;
    end else if (w.op == OP_JP_HL) begin
      d.uncond = 1'b1;
    end else if ((w.op & MSK_C7) == VAL_JP_CC) begin
      d.length = LEN_3; d.cond = 1'b1; d.tgt_ok = 1'b1; d.target = {w.b2, w.b1};
    end else if ((w.op & MSK_E7) == VAL_JR_CC) begin
      d.length = LEN_2; d.cond = 1'b1; d.tgt_ok = 1'b1; d.target = rel_dest; d.rel = w.b1;
    end else if (w.op == OP_CALL) begin
      d.length = LEN_3; d.call = 1'b1; d.tgt_ok = 1'b1; d.target = {w.b2, w.b1};
    end else if ((w.op & MSK_C7) == VAL_CL_CC) begin
      d.length = LEN_3; d.cond = 1'b1; d.call = 1'b1; d.tgt_ok = 1'b1;
      d.target = {w.b2, w.b1};
    end else if ((w.op & MSK_C7) == VAL_RET_CC) begin
      d.cond = 1'b1; d.ret = 1'b1;
    end else if ((w.op & MSK_C7) == VAL_RST) begin
      d.call = 1'b1; d.tgt_ok = 1'b1; d.target = {8'h00, w.op & MSK_RST};
    end else if (w.op == OP_DJNZ) begin
      d.length = LEN_2; d.cond = 1'b1; d.tgt_ok = 1'b1; d.target = rel_dest; d.rel = w.b1;
    end else if (w.op == PFX_ED) begin
      d.length = LEN_2;
      if (w.b1 == ED_RETI || w.b1 == ED_RETN) begin
        d.uncond = 1'b1; d.ret = 1'b1;
      end else if ((w.b1 & MSK_C7) == VAL_ED_LD) begin
        d.length = LEN_4;
      end
    end else if (w.op == PFX_DD || w.op == PFX_FD) begin
      if (w.b1 == OP_JP_HL) begin
        d.length = LEN_2; d.uncond = 1'b1;
      end else if (w.b1 == PFX_CB) begin
        d.length = LEN_4;
      end else if ((w.b1 & MSK_C0) == VAL_IX_40 || (w.b1 & MSK_C7) == VAL_IX_46) begin
        d.length = LEN_3;
      end else if (w.b1 == IX_LD_NN || w.b1 == IX_ST_NN || w.b1 == IX_LD_IND ||
                   w.b1 == IX_ST_N) begin
        d.length = LEN_4;
      end else begin
        d.length = LEN_2;
      end
    end else if (w.op == PFX_CB) begin
      d.length = LEN_2;
    end else if ((w.op & MSK_C7) == VAL_LD_N) begin
      d.length = LEN_2;
    end else if ((w.op & MSK_CF) == VAL_LD_NN) begin
      d.length = LEN_3;
    end else if ((w.op & MSK_C7) == VAL_ALU_N) begin
      d.length = LEN_2;
    end
    return d;
  endfunction

  task automatic add_word(input logic [15:0] addr, input logic [7:0] op,
                          input logic [7:0] b1, input logic [7:0] b2);
    fetch_q.push_back('{addr: addr, op: op, b1: b1, b2: b2});
  endtask

  // mostly well-formed flow, immediate-operand and prefix words with random operands, the rest noise
  function automatic fetch_t random_word();
    fetch_t     w;
    logic [2:0] cc;
    cc     = 3'($urandom_range(7));
    w.addr = 16'($urandom);
    w.op   = 8'($urandom);
    w.b1   = 8'($urandom);
    w.b2   = 8'($urandom);
    case ($urandom_range(7))
      0:       w.addr = 16'hFF80 | 16'($urandom_range(127));
      1:       w.addr = 16'($urandom_range(127));
      default: ;
    endcase
    case ($urandom_range(9))
      4, 5: begin
        case ($urandom_range(11))
          0:  w.op = OP_JP;
          1:  w.op = OP_JR;
          2:  w.op = OP_RET;
          3:  w.op = OP_JP_HL;
          4:  w.op = VAL_JP_CC | {2'b00, cc, 3'b000};
          5:  w.op = VAL_JR_CC | {3'b000, cc[1:0], 3'b000};
          6:  w.op = OP_CALL;
          7:  w.op = VAL_CL_CC | {2'b00, cc, 3'b000};
          8:  w.op = VAL_RET_CC | {2'b00, cc, 3'b000};
          9:  w.op = VAL_RST | {2'b00, cc, 3'b000};
          10: w.op = OP_DJNZ;
          default: w.op = PFX_CB;
        endcase
      end
      6, 7: begin
        case ($urandom_range(3))
          0: w.op = VAL_LD_N | {2'b00, cc, 3'b000};
          1: w.op = VAL_LD_NN | {2'b00, cc[1:0], 4'b0000};
          2: w.op = VAL_ALU_N | {2'b00, cc, 3'b000};
          default: w.op = OP_HALT;
        endcase
      end
      8, 9: begin
        case ($urandom_range(2))
          0: w.op = PFX_ED;
          1: w.op = PFX_DD;
          default: w.op = PFX_FD;
        endcase
        case ($urandom_range(9))
          0: w.b1 = ED_RETN;
          1: w.b1 = ED_RETI;
          2: w.b1 = VAL_ED_LD | {2'b00, cc, 3'b000};
          3: w.b1 = OP_JP_HL;
          4: w.b1 = PFX_CB;
          5: w.b1 = VAL_IX_46 | {2'b00, cc, 3'b000};
          6: begin
            case (cc[1:0])
              2'd0: w.b1 = IX_LD_NN;
              2'd1: w.b1 = IX_ST_NN;
              2'd2: w.b1 = IX_LD_IND;
              default: w.b1 = IX_ST_N;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin : drive_proc
    fetch_t w;
    logic   calm;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_q.push_back(predict_decode('{addr: instr_address_i, op: opcode_byte_i,
                                            b1: second_byte_i, b2: third_byte_i}));
        words_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        calm = (words_sent >= CalmFirst) && (words_sent < CalmLast);
        if (fetch_q.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
          w = fetch_q.pop_front();
          in_valid_i      <= 1'b1;
          instr_address_i <= w.addr;
          opcode_byte_i   <= w.op;
          second_byte_i   <= w.b1;
          third_byte_i    <= w.b2;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_proc
    decode_t exp_word;
    logic    calm;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (decode_q.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          exp_word = decode_q.pop_front();
          check_field("instr_length", exp_word.length, instr_length_o);
          check_field("uncond_jump", exp_word.uncond, uncond_jump_o);
          check_field("conditional", exp_word.cond, conditional_o);
          check_field("is_return", exp_word.ret, is_return_o);
          check_field("is_call", exp_word.call, is_call_o);
          check_field("has_target", exp_word.tgt_ok, has_target_o);
          check_field("branch_target", exp_word.target, branch_target_o);
          check_field("rel_offset", exp_word.rel, rel_offset_o);
          words_checked++;
          if (exp_word.tgt_ok) targets_seen++;
        end
      end
      calm = (words_checked >= CalmFirst) && (words_checked < CalmLast);
      out_stall_i <= !calm && ($urandom_range(99) < 14);
    end
  end

  initial begin
    #2ms;
    $display("z80_branch_predecoder verification failed");
    $finish;
  end

  initial begin : stim_proc
    int unsigned i;
    // extremes, wrap-around of relative targets, every flow class and prefix rule
    add_word(16'h0000, OP_JP, 8'hFF, 8'hFF);
    add_word(16'hFFFF, OP_JP, 8'h00, 8'h00);
    add_word(16'hFFFF, OP_JR, 8'h7F, 8'h00);
    add_word(16'h0000, OP_JR, 8'h80, 8'hAA);
    add_word(16'h1234, OP_RET, 8'hFF, 8'hFF);
    add_word(16'hFFFE, OP_JP_HL, 8'h55, 8'hAA);
    add_word(16'h4000, VAL_JP_CC | 8'h38, 8'h34, 8'h12);
    add_word(16'hFFF0, VAL_JR_CC | 8'h18, 8'hFE, 8'h00);
    add_word(16'h8000, OP_CALL, 8'h00, 8'h80);
    add_word(16'h0001, VAL_CL_CC, 8'hFF, 8'hFF);
    add_word(16'hABCD, VAL_RET_CC | 8'h38, 8'h00, 8'h00);
    add_word(16'h0100, VAL_RST, 8'hFF, 8'hFF);
    add_word(16'h0200, VAL_RST | MSK_RST, 8'h00, 8'h00);
    add_word(16'h8000, OP_DJNZ, 8'h80, 8'h00);
    add_word(16'h0010, PFX_ED, ED_RETN, 8'h00);
    add_word(16'h0020, PFX_ED, ED_RETI, 8'hFF);
    add_word(16'h0030, PFX_ED, VAL_ED_LD, 8'h00);
    add_word(16'h0040, PFX_ED, 8'h7B, 8'hFF);
    add_word(16'h0050, PFX_DD, OP_JP_HL, 8'h12);
    add_word(16'h0060, PFX_FD, PFX_CB, 8'h05);
    add_word(16'h0070, PFX_DD, OP_HALT, 8'h00);
    add_word(16'h0080, PFX_FD, IX_LD_NN, 8'h34);
    add_word(16'h0090, PFX_DD, OP_NOP, 8'h00);
    add_word(16'h00A0, PFX_CB, 8'hFF, 8'hFF);
    add_word(16'h00B0, VAL_LD_N, 8'h00, 8'h00);
    add_word(16'h00C0, VAL_LD_NN | 8'h30, 8'hFF, 8'hFF);
    add_word(16'h00D0, VAL_ALU_N | 8'h38, 8'h01, 8'h00);
    add_word(16'h00E0, OP_HALT, 8'hFF, 8'hFF);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i < RandomWords / 2; i++) fetch_q.push_back(random_word());
    // hold the sender until the pipeline has drained completely
    @(negedge clk_i);
    while (fetch_q.size() != 0 || in_valid_i || decode_q.size() != 0) @(negedge clk_i);
    for (i = RandomWords / 2; i < RandomWords; i++) fetch_q.push_back(random_word());
    @(negedge clk_i);
    while (fetch_q.size() != 0 || in_valid_i || decode_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    $display("%0d words decoded and checked across all opcode classes and prefixes,",
             words_checked);
    $display("%0d of them with a static branch target, under random idling on both sides",
             targets_seen);
    if (mismatches == 0) begin
      $display("z80_branch_predecoder verification clean");
    end else begin
      $display("z80_branch_predecoder verification failed");
    end
    $finish;
  end

endmodule

### z80_branch_predecoder.f
+incdir+rtl/core
rtl/core/z80bp_pkg.sv
rtl/core/z80bp_decode.sv
rtl/core/z80_branch_predecoder.sv
test/tb_z80_branch_predecoder.sv
